FILE: sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Depends on nothing; the interfaces, controller, datapath and top level use it.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int COLIN_W  = 7;
   localparam int ROWIN_W  = 5;
   localparam int CURSOR_W = 11;
   localparam int CELL_W   = CHAR_W + ATTR_W;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd15;

   localparam logic ACT_PRINT = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic clear_step;
      logic scroll_step;
      logic rd_capture;
      logic rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_read;
      logic need_scroll;
      logic cnt_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: sv/tcw_req_if.sv
// Request channel of the text console writer: valid/ready plus one item.
// Depends on tcw_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tcw_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [tcw_pkg::CHAR_W-1:0]    character;
   logic [tcw_pkg::ATTR_W-1:0]    attribute;
   logic                          at_position;
   logic [tcw_pkg::COLIN_W-1:0]   column;
   logic [tcw_pkg::ROWIN_W-1:0]   row;

   modport source (output valid, action, character, attribute, at_position, column, row,
                   input ready);
   modport sink   (input valid, action, character, attribute, at_position, column, row,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/tcw_rsp_if.sv
// Response channel of the text console writer: valid/ready plus one result.
// Depends on tcw_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::CURSOR_W-1:0]  cursor_cell;
   logic                          scrolled;
   logic [tcw_pkg::CHAR_W-1:0]    read_character;
   logic [tcw_pkg::ATTR_W-1:0]    read_attribute;

   modport source (output valid, cursor_cell, scrolled, read_character, read_attribute,
                   input ready);
   modport sink   (input valid, cursor_cell, scrolled, read_character, read_attribute,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/tcw_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/tcw_ctrl.sv
// Controller of the text console writer: sequences clear, execute, read,
// scroll and response hand-off. Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire tcw_pkg::status_type stat,
   output tcw_pkg::cmd_type         cmd
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_READ,
      S_SCROLL,
      S_SCROLL_END,
      S_HOLD
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.cnt_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.is_read) begin
               state_in = S_READ;
            end else if (stat.need_scroll) begin
               state_in = S_SCROLL;
            end else if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_HOLD;
            end
         end
         S_READ: begin
            cmd.rd_capture = 1'b1;
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_HOLD;
            end
         end
         S_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (stat.cnt_last) state_in = S_SCROLL_END;
         end
         S_SCROLL_END: begin
            // last row-fill write retires here
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

FILE: sv/tcw_datapath.sv
// Datapath of the text console writer: captured item, cursor, screen RAM,
// sweep counter for clear and scroll, config register and response register.
// Depends on tcw_pkg and tcw_ram.
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tcw_pkg::cmd_type               cmd,
   output tcw_pkg::status_type                 stat,
   input  wire logic                           csr_wr_en,
   input  wire logic [tcw_pkg::ATTR_W-1:0]     csr_wr_data,
   input  wire logic                           req_action,
   input  wire logic [tcw_pkg::CHAR_W-1:0]     req_character,
   input  wire logic [tcw_pkg::ATTR_W-1:0]     req_attribute,
   input  wire logic                           req_at_position,
   input  wire logic [tcw_pkg::COLIN_W-1:0]    req_column,
   input  wire logic [tcw_pkg::ROWIN_W-1:0]    req_row,
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid,
   output logic [tcw_pkg::CURSOR_W-1:0]        rsp_cursor_cell,
   output logic                                rsp_scrolled,
   output logic [tcw_pkg::CHAR_W-1:0]          rsp_read_character,
   output logic [tcw_pkg::ATTR_W-1:0]          rsp_read_attribute
);
   import tcw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);

   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM    = ADDR_W'(CELLS - COLUMNS);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

   // captured item
   logic              act_ff, at_pos_ff;
   logic [CHAR_W-1:0] ch_ff;
   logic [ATTR_W-1:0] attr_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   // cursor
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ADDR_W-1:0] cur_lin_ff, cur_lin_in;

   logic [ATTR_W-1:0] def_attr_ff;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              sc_pend_ff;
   logic [ADDR_W-1:0] sc_addr_ff;
   logic              sc_copy_ff;

   logic              scroll_flag_ff, scroll_flag_in;
   logic [CELL_W-1:0] rdcell_ff, rdcell_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_W-1:0] rsp_cursor_ff;
   logic                rsp_scrolled_ff;
   logic [CELL_W-1:0]   rsp_cell_ff;

   // execute-stage decode
   logic              is_nl, is_bs, use_cur, last_col, last_row, need_scroll, in_copy;
   logic [ROW_W-1:0]  sel_row;
   logic [COL_W-1:0]  sel_col;
   logic [ADDR_W-1:0] sel_addr, bs_addr;

   // RAM ports
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CELL_W-1:0] wr_data, rd_data;

   // saturate the requested column and row
   always_comb begin
      col_in = (int'(req_column) > COLUMNS - 1) ? LAST_COL : COL_W'(req_column);
      row_in = (int'(req_row) > ROWS - 1) ? LAST_ROW : ROW_W'(req_row);
   end

   always_comb begin
      is_nl    = (ch_ff == CH_NEWLINE);
      is_bs    = (ch_ff == CH_BACKSPACE);
      use_cur  = (act_ff == ACT_PRINT) && (is_bs || !at_pos_ff);
      sel_row  = use_cur ? cur_row_ff : row_ff;
      sel_col  = use_cur ? cur_col_ff : col_ff;
      sel_addr = ADDR_W'(int'(sel_row) * COLUMNS + int'(sel_col));
      bs_addr  = (cur_lin_ff == '0) ? '0 : cur_lin_ff - ADDR_W'(1);
      last_col = (sel_col == LAST_COL);
      last_row = (sel_row == LAST_ROW);
      need_scroll = (act_ff == ACT_PRINT) && !is_bs && last_row && (is_nl || last_col);
      in_copy  = (cnt_ff < BOTTOM);
   end

   // next cursor
   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      cur_lin_in = cur_lin_ff;
      if (cmd.exec && (act_ff == ACT_PRINT)) begin
         if (is_bs) begin
            cur_lin_in = bs_addr;
            if (cur_lin_ff != '0) begin
               if (cur_col_ff == '0) begin
                  cur_row_in = cur_row_ff - ROW_W'(1);
                  cur_col_in = LAST_COL;
               end else begin
                  cur_col_in = cur_col_ff - COL_W'(1);
               end
            end
         end else if (need_scroll) begin
            cur_row_in = LAST_ROW;
            cur_col_in = '0;
            cur_lin_in = BOTTOM;
         end else if (is_nl) begin
            cur_row_in = sel_row + ROW_W'(1);
            cur_col_in = '0;
            cur_lin_in = ADDR_W'(int'(sel_addr) + COLUMNS - int'(sel_col));
         end else if (last_col) begin
            cur_row_in = sel_row + ROW_W'(1);
            cur_col_in = '0;
            cur_lin_in = sel_addr + ADDR_W'(1);
         end else begin
            cur_row_in = sel_row;
            cur_col_in = sel_col + COL_W'(1);
            cur_lin_in = sel_addr + ADDR_W'(1);
         end
      end
   end

   // RAM port selection; the sources are mutually exclusive by state
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = sel_addr;
      wr_data = {attr_ff, ch_ff};
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff;
         wr_data = {RESET_ATTR, CH_SPACE};
      end else if (sc_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = sc_addr_ff;
         wr_data = sc_copy_ff ? rd_data : {def_attr_ff, CH_SPACE};
      end else if (cmd.exec && (act_ff == ACT_PRINT) && !is_nl) begin
         wr_en   = 1'b1;
         wr_addr = is_bs ? bs_addr : sel_addr;
         wr_data = {attr_ff, (is_bs ? CH_SPACE : ch_ff)};
      end

      rd_en   = 1'b0;
      rd_addr = sel_addr;
      if (cmd.exec) begin
         rd_en = (act_ff == ACT_READ);
      end else if (cmd.scroll_step) begin
         // fetch the cell one row below the one being written
         rd_en   = in_copy;
         rd_addr = ADDR_W'(int'(cnt_ff) + COLUMNS);
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clear_step || cmd.scroll_step) begin
         cnt_in = (cnt_ff == LAST_CELL) ? '0 : cnt_ff + ADDR_W'(1);
      end
      scroll_flag_in = cmd.exec ? need_scroll : scroll_flag_ff;
      rdcell_in = rdcell_ff;
      if (cmd.exec) begin
         rdcell_in = '0;
      end else if (cmd.rd_capture) begin
         rdcell_in = rd_data;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         cur_lin_ff   <= '0;
         def_attr_ff  <= RESET_ATTR;
         cnt_ff       <= '0;
         sc_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         cur_lin_ff   <= cur_lin_in;
         if (csr_wr_en) def_attr_ff <= csr_wr_data;
         cnt_ff       <= cnt_in;
         sc_pend_ff   <= cmd.scroll_step;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff    <= req_action;
         ch_ff     <= req_character;
         attr_ff   <= (req_attribute == '0) ? def_attr_ff : req_attribute;
         at_pos_ff <= req_at_position;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
      sc_addr_ff     <= cnt_ff;
      sc_copy_ff     <= in_copy;
      scroll_flag_ff <= scroll_flag_in;
      rdcell_ff      <= rdcell_in;
      if (cmd.rsp_load) begin
         rsp_cursor_ff   <= CURSOR_W'(cur_lin_in);
         rsp_scrolled_ff <= scroll_flag_in;
         rsp_cell_ff     <= rdcell_in;
      end
   end

   always_comb begin
      stat.is_read     = (act_ff == ACT_READ);
      stat.need_scroll = need_scroll;
      stat.cnt_last    = (cnt_ff == LAST_CELL);
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_cell    = rsp_cursor_ff;
   assign rsp_scrolled       = rsp_scrolled_ff;
   assign rsp_read_character = rsp_cell_ff[CHAR_W-1:0];
   assign rsp_read_attribute = rsp_cell_ff[CELL_W-1:CHAR_W];

endmodule

`default_nettype wire

FILE: sv/text_console_writer_top.sv
// Text console writer top level: channel interfaces, controller and datapath.
// Depends on tcw_pkg, tcw_req_if, tcw_rsp_if, tcw_ctrl, tcw_datapath.
//
// Usage:
//   req_chan carries print or read transactions, rsp_chan returns exactly one
//   result transaction per request, in order. csr_wr_en/csr_wr_data set the
//   default attribute; write it only while the block is idle.
//   A print's result is loaded into the output register after the execute
//   state; a read adds the registered screen RAM read. A print that fills
//   the last cell, or a newline on the bottom row, scrolls: every cell is
//   rewritten once through the single RAM write port. Items are processed
//   one at a time: a new request is accepted only once the last one has
//   loaded its result.
//   Reset: after reset the screen RAM is swept to spaces with attribute 15,
//   all COLUMNS*ROWS cells (2000 by default), with req_chan.ready low; config
//   writes are taken during the sweep. The cursor resets to cell 0.
//   Stall: the result sits in an output register; the next request is still
//   accepted and executed, and its result waits until rsp_chan.ready frees
//   the register.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_top #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   tcw_req_if.sink                         req_chan,
   tcw_rsp_if.source                       rsp_chan,
   input  wire logic                       csr_wr_en,
   input  wire logic [tcw_pkg::ATTR_W-1:0] csr_wr_data
);
   import tcw_pkg::*;

   cmd_type    cmd;
   status_type stat;
   logic       ready;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_action         (req_chan.action),
      .req_character      (req_chan.character),
      .req_attribute      (req_chan.attribute),
      .req_at_position    (req_chan.at_position),
      .req_column         (req_chan.column),
      .req_row            (req_chan.row),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_cursor_cell    (rsp_chan.cursor_cell),
      .rsp_scrolled       (rsp_chan.scrolled),
      .rsp_read_character (rsp_chan.read_character),
      .rsp_read_attribute (rsp_chan.read_attribute)
   );

   assign req_chan.ready = ready;

endmodule

`default_nettype wire
